// ----- rtl/ssdt_pkg.sv -----
// Shared types, codes and reset values for the stop sign dwell table.
package ssdt_pkg;

	localparam int SIGN_SLOTS_DEF = 256;
	localparam int DIST_BITS_DEF  = 20;

	localparam int ID_W       = 8;
	localparam int ID_SLOTS   = 1 << ID_W;
	localparam int SPEED_W    = 16;
	localparam int TIME_W     = 32;
	localparam int CFG_DIST_W = 20;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 20;
	localparam int TGT_W      = 21;

	localparam logic [TGT_W-1:0] TARGET_MAX = '1;

	typedef enum logic [1:0] {
		PH_APPROACH = 2'd0,
		PH_HOLD     = 2'd1,
		PH_CREEP    = 2'd2,
		PH_CLEARED  = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		CK_NONE = 2'd0,
		CK_STOP = 2'd1,
		CK_CAP  = 2'd2
	} ckind_t;

	typedef enum logic [1:0] {
		SK_OTHER = 2'd0,
		SK_STOP  = 2'd1,
		SK_YIELD = 2'd2
	} skind_t;

	typedef enum logic {
		OP_SIGN  = 1'b0,
		OP_SWEEP = 1'b1
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DETECT_SPEED  = 3'd0,
		REG_LINE_TOL      = 3'd1,
		REG_HOLD_TIME     = 3'd2,
		REG_CREEP_DUR     = 3'd3,
		REG_CREEP_SPEED   = 3'd4,
		REG_CREEP_ADVANCE = 3'd5,
		REG_YIELD_SPEED   = 3'd6,
		REG_STOP_MARGIN   = 3'd7
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ST_INIT  = 2'd0,
		ST_IDLE  = 2'd1,
		ST_EXEC  = 2'd2,
		ST_SWEEP = 2'd3
	} state_t;

	typedef struct packed {
		logic [SPEED_W-1:0]    detect_speed;
		logic [CFG_DIST_W-1:0] line_tol;
		logic [SPEED_W-1:0]    hold_time;
		logic [SPEED_W-1:0]    creep_dur;
		logic [SPEED_W-1:0]    crawl_speed;
		logic [CFG_DIST_W-1:0] crawl_reach;
		logic [SPEED_W-1:0]    yield_speed;
		logic [CFG_DIST_W-1:0] line_margin;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		detect_speed:  16'd300,
		line_tol:      20'd1000,
		hold_time:     16'd2000,
		creep_dur:     16'd1000,
		crawl_speed:   16'd1000,
		crawl_reach:   20'd1000,
		yield_speed:   16'd2000,
		line_margin:   20'd500
	};

	// one word of the slot state memory
	typedef struct packed {
		logic   seen;
		phase_t phase;
	} slot_t;

	typedef struct packed {
		ckind_t             kind;
		logic [TGT_W-1:0]   target;
		logic [SPEED_W-1:0] cap;
		logic               from_yield;
		phase_t             phase;
	} res_t;

	// write-back request from the evaluator
	typedef struct packed {
		logic   st_we;
		phase_t phase;
		logic   start_we;
	} wb_t;

endpackage

// ----- rtl/stop_sign_dwell_table_top.sv -----
// Stop sign dwell table: control, slot memories and result register.
//
// Channels: input items on in_valid/in_ready with one port per field; results on
// out_valid/out_ready; register writes on cfg_valid/cfg_ready (always ready, index
// and data, taken at any time).
// A sign item reads its slot in the cycle it is accepted; in the execute state it is
// evaluated, and once the output register is free it is written back and its result
// is loaded into the output register. The next item is accepted once that write-back
// is done, as the slot memories are read, modified and written back per item.
// An end-of-frame item walks the slot state memory one slot per cycle; its result
// is loaded once the last slot is written and the output register is free.
// After reset a clearing pass writes every slot to approach with its seen mark
// low; in_ready stays low until that pass is done.
// While the receiver stalls the result holds in the output register; one more
// item may be accepted and then waits in evaluation until the register frees.
module stop_sign_dwell_table_top #(
	parameter int SIGN_SLOTS = ssdt_pkg::SIGN_SLOTS_DEF,
	parameter int DIST_BITS  = ssdt_pkg::DIST_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            operation,
	input  logic [ssdt_pkg::ID_W-1:0]       sign_id,
	input  logic [1:0]                      sign_kind,
	input  logic [DIST_BITS-1:0]            sign_distance,
	input  logic                            paired_valid,
	input  logic [DIST_BITS-1:0]            paired_distance,
	input  logic [ssdt_pkg::SPEED_W-1:0]    ego_speed,
	input  logic [ssdt_pkg::TIME_W-1:0]     now_ms,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [1:0]                      constraint_kind,
	output logic [ssdt_pkg::TGT_W-1:0]      target_distance,
	output logic [ssdt_pkg::SPEED_W-1:0]    speed_cap,
	output logic                            from_yield,
	output logic [1:0]                      phase_after,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [ssdt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ssdt_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int SLOT_W = $clog2(SIGN_SLOTS);
	localparam int MW = (DIST_BITS > ssdt_pkg::CFG_DIST_W) ? DIST_BITS : ssdt_pkg::CFG_DIST_W;
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SIGN_SLOTS - 1);

	ssdt_pkg::cfg_t   cfg;
	ssdt_pkg::state_t state_q, state_d;

	logic [SLOT_W-1:0] idx_q;
	logic              idx_last;
	logic              in_acc;
	logic              out_free;
	logic              out_load;

	// sign id to slot, a constant table
	logic [SLOT_W-1:0] slot_lut [ssdt_pkg::ID_SLOTS];
	for (genvar g = 0; g < ssdt_pkg::ID_SLOTS; g++) begin : g_slot
		assign slot_lut[g] = SLOT_W'(g % SIGN_SLOTS);
	end

	// item registers
	logic                         op_q;
	logic [1:0]                   kind_q;
	logic [DIST_BITS-1:0]         dist_q;
	logic [MW-1:0]                adj_q;
	logic [ssdt_pkg::SPEED_W-1:0] speed_q;
	logic [ssdt_pkg::TIME_W-1:0]  now_q;
	logic [SLOT_W-1:0]            slot_q;

	logic [MW-1:0] d_ext;
	logic [MW-1:0] m_ext;
	logic [MW-1:0] adj_d;

	// memory ports
	logic                        rd_en;
	logic [SLOT_W-1:0]           rd_addr;
	ssdt_pkg::slot_t             st_rd;
	logic                        st_we;
	logic [SLOT_W-1:0]           st_waddr;
	ssdt_pkg::slot_t             st_wdata;
	ssdt_pkg::slot_t             sweep_wdata;
	logic                        start_we;
	logic [ssdt_pkg::TIME_W-1:0] start_rd;

	ssdt_pkg::res_t res;
	ssdt_pkg::wb_t  wb;
	ssdt_pkg::res_t out_q;
	logic           out_valid_q;

	ssdt_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	assign cfg_ready = 1'b1;

	assign in_acc   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign idx_last = idx_q == LAST_SLOT;

	// stop distance less the margin, taken at acceptance
	always_comb begin
		d_ext = paired_valid ? MW'(paired_distance) : MW'(sign_distance);
		m_ext = MW'(cfg.line_margin);
		adj_d = (d_ext > m_ext) ? d_ext - m_ext : '0;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ssdt_pkg::ST_INIT: begin
				if (idx_last) begin
					state_d = ssdt_pkg::ST_IDLE;
				end
			end
			ssdt_pkg::ST_IDLE: begin
				if (in_acc) begin
					state_d = (operation == ssdt_pkg::OP_SWEEP) ?
						ssdt_pkg::ST_SWEEP : ssdt_pkg::ST_EXEC;
				end
			end
			ssdt_pkg::ST_SWEEP: begin
				if (idx_last) begin
					state_d = ssdt_pkg::ST_EXEC;
				end
			end
			ssdt_pkg::ST_EXEC: begin
				if (out_free) begin
					state_d = ssdt_pkg::ST_IDLE;
				end
			end
			default: state_d = ssdt_pkg::ST_INIT;
		endcase
	end

	// sweep: clear unseen slots that left approach, drop every seen mark
	always_comb begin
		sweep_wdata.seen  = 1'b0;
		sweep_wdata.phase = (!st_rd.seen && st_rd.phase != ssdt_pkg::PH_APPROACH) ?
			ssdt_pkg::PH_CLEARED : st_rd.phase;
	end

	always_comb begin
		in_ready = 1'b0;
		rd_en    = 1'b0;
		rd_addr  = (operation == ssdt_pkg::OP_SWEEP) ? '0 : slot_lut[sign_id];
		st_we    = 1'b0;
		st_waddr = idx_q;
		st_wdata = '{seen: 1'b0, phase: ssdt_pkg::PH_APPROACH};
		out_load = 1'b0;
		start_we = 1'b0;
		case (state_q)
			ssdt_pkg::ST_INIT: begin
				st_we = 1'b1;
			end
			ssdt_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				rd_en    = in_valid;
			end
			ssdt_pkg::ST_SWEEP: begin
				// write slot idx while reading the one after it
				rd_en    = !idx_last;
				rd_addr  = idx_q + 1'b1;
				st_we    = 1'b1;
				st_wdata = sweep_wdata;
			end
			ssdt_pkg::ST_EXEC: begin
				out_load = out_free;
				st_we    = out_free && wb.st_we;
				st_waddr = slot_q;
				st_wdata = '{seen: 1'b1, phase: wb.phase};
				start_we = out_free && wb.start_we;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ssdt_pkg::ST_INIT;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ssdt_pkg::ST_IDLE) begin
				idx_q <= '0;
			end else begin
				idx_q <= idx_q + 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_q    <= operation;
			kind_q  <= sign_kind;
			dist_q  <= sign_distance;
			adj_q   <= adj_d;
			speed_q <= ego_speed;
			now_q   <= now_ms;
			slot_q  <= slot_lut[sign_id];
		end
		if (out_load) begin
			out_q <= res;
		end
	end

	ssdt_ram #(
		.WIDTH ($bits(ssdt_pkg::slot_t)),
		.DEPTH (SIGN_SLOTS)
	) u_state_ram (
		.clk   (clk),
		.we    (st_we),
		.waddr (st_waddr),
		.wdata (st_wdata),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (st_rd)
	);

	ssdt_ram #(
		.WIDTH (ssdt_pkg::TIME_W),
		.DEPTH (SIGN_SLOTS)
	) u_start_ram (
		.clk   (clk),
		.we    (start_we),
		.waddr (slot_q),
		.wdata (now_q),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (start_rd)
	);

	ssdt_eval #(
		.DIST_BITS (DIST_BITS)
	) u_eval (
		.op       (op_q),
		.kind     (kind_q),
		.raw_dist (dist_q),
		.adj      (adj_q),
		.speed    (speed_q),
		.now      (now_q),
		.phase_rd (st_rd.phase),
		.start_rd (start_rd),
		.cfg      (cfg),
		.res      (res),
		.wb       (wb)
	);

	assign out_valid       = out_valid_q;
	assign constraint_kind = out_q.kind;
	assign target_distance = out_q.target;
	assign speed_cap       = out_q.cap;
	assign from_yield      = out_q.from_yield;
	assign phase_after     = out_q.phase;

	a_accept_starts_work: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (state_q == ssdt_pkg::ST_EXEC || state_q == ssdt_pkg::ST_SWEEP))
		else $error("accepted item did not start work");

	a_idle_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ssdt_pkg::ST_IDLE |-> !st_we && !start_we)
		else $error("slot memory written while idle");

	a_start_with_state: assert property (@(posedge clk) disable iff (!arst_n)
		start_we |-> st_we && out_load && wb.phase != ssdt_pkg::PH_APPROACH)
		else $error("start time written without a phase change");

	a_sweep_steps: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ssdt_pkg::ST_SWEEP && $past(state_q) == ssdt_pkg::ST_SWEEP
		|-> idx_q == SLOT_W'($past(idx_q) + 1'b1))
		else $error("sweep skipped a slot");

endmodule

// ----- rtl/ssdt_ram.sv -----
// Single-port-write, single-port-read synchronous RAM with registered read data.
module ssdt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- rtl/ssdt_cfg_regs.sv -----
// Configuration register file.
module ssdt_cfg_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            wr_en,
	input  logic [ssdt_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [ssdt_pkg::CFG_DATA_W-1:0] wr_data,
	output ssdt_pkg::cfg_t                  cfg
);

	ssdt_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= ssdt_pkg::CFG_RESET;
		end else if (wr_en) begin
			case (ssdt_pkg::cfg_idx_t'(wr_index))
				ssdt_pkg::REG_DETECT_SPEED:  cfg_q.detect_speed <= wr_data[15:0];
				ssdt_pkg::REG_LINE_TOL:      cfg_q.line_tol     <= wr_data;
				ssdt_pkg::REG_HOLD_TIME:     cfg_q.hold_time    <= wr_data[15:0];
				ssdt_pkg::REG_CREEP_DUR:     cfg_q.creep_dur    <= wr_data[15:0];
				ssdt_pkg::REG_CREEP_SPEED:   cfg_q.crawl_speed  <= wr_data[15:0];
				ssdt_pkg::REG_CREEP_ADVANCE: cfg_q.crawl_reach  <= wr_data;
				ssdt_pkg::REG_YIELD_SPEED:   cfg_q.yield_speed  <= wr_data[15:0];
				ssdt_pkg::REG_STOP_MARGIN:   cfg_q.line_margin  <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- rtl/ssdt_eval.sv -----
// Per-item evaluation: phase update of a stop slot and the constraint result.
module ssdt_eval #(
	parameter int DIST_BITS = ssdt_pkg::DIST_BITS_DEF,
	localparam int MW = (DIST_BITS > ssdt_pkg::CFG_DIST_W) ? DIST_BITS : ssdt_pkg::CFG_DIST_W
) (
	input  logic                          op,
	input  logic [1:0]                    kind,
	input  logic [DIST_BITS-1:0]          raw_dist,
	input  logic [MW-1:0]                 adj,
	input  logic [ssdt_pkg::SPEED_W-1:0]  speed,
	input  logic [ssdt_pkg::TIME_W-1:0]   now,
	input  ssdt_pkg::phase_t              phase_rd,
	input  logic [ssdt_pkg::TIME_W-1:0]   start_rd,
	input  ssdt_pkg::cfg_t                cfg,
	output ssdt_pkg::res_t                res,
	output ssdt_pkg::wb_t                 wb
);

	localparam int SUM_W = MW + 1;
	localparam int CMP_W = (SUM_W > ssdt_pkg::TGT_W) ? SUM_W : ssdt_pkg::TGT_W;

	logic [SUM_W-1:0]              cap_sum;
	logic [ssdt_pkg::TGT_W-1:0]    tgt_dist;
	logic [ssdt_pkg::TGT_W-1:0]    tgt_adj;
	logic [ssdt_pkg::TGT_W-1:0]    tgt_cap;
	logic [ssdt_pkg::TIME_W-1:0]   elapsed;
	logic                          hold_run;
	logic                          creep_done;
	logic                          arrive;
	logic                          is_stop;
	logic                          is_yield;

	assign cap_sum = SUM_W'(adj) + SUM_W'(cfg.crawl_reach);

	assign tgt_dist = (CMP_W'(raw_dist) > CMP_W'(ssdt_pkg::TARGET_MAX)) ?
		ssdt_pkg::TARGET_MAX : ssdt_pkg::TGT_W'(raw_dist);
	assign tgt_adj = (CMP_W'(adj) > CMP_W'(ssdt_pkg::TARGET_MAX)) ?
		ssdt_pkg::TARGET_MAX : ssdt_pkg::TGT_W'(adj);
	assign tgt_cap = (CMP_W'(cap_sum) > CMP_W'(ssdt_pkg::TARGET_MAX)) ?
		ssdt_pkg::TARGET_MAX : ssdt_pkg::TGT_W'(cap_sum);

	// wrapping time difference against the recorded start
	assign elapsed    = now - start_rd;
	assign hold_run   = elapsed < ssdt_pkg::TIME_W'(cfg.hold_time);
	assign creep_done = elapsed >= ssdt_pkg::TIME_W'(cfg.creep_dur);
	assign arrive     = (speed < cfg.detect_speed) && (adj < MW'(cfg.line_tol));

	assign is_stop  = (op == ssdt_pkg::OP_SIGN) && (kind == ssdt_pkg::SK_STOP);
	assign is_yield = (op == ssdt_pkg::OP_SIGN) && (kind == ssdt_pkg::SK_YIELD);

	always_comb begin
		res = '{kind: ssdt_pkg::CK_NONE, target: '0, cap: '0, from_yield: 1'b0,
			phase: ssdt_pkg::PH_APPROACH};
		wb  = '{st_we: 1'b0, phase: ssdt_pkg::PH_APPROACH, start_we: 1'b0};
		if (is_yield) begin
			res.kind       = ssdt_pkg::CK_CAP;
			res.target     = tgt_dist;
			res.cap        = cfg.yield_speed;
			res.from_yield = 1'b1;
		end else if (is_stop) begin
			wb.st_we = 1'b1;
			wb.phase = phase_rd;
			case (phase_rd)
				ssdt_pkg::PH_APPROACH: begin
					if (arrive) begin
						wb.phase    = ssdt_pkg::PH_HOLD;
						wb.start_we = 1'b1;
					end
					res.kind   = ssdt_pkg::CK_STOP;
					res.target = tgt_adj;
				end
				ssdt_pkg::PH_HOLD: begin
					if (hold_run) begin
						res.kind   = ssdt_pkg::CK_STOP;
						res.target = tgt_adj;
					end else begin
						// creep starts now, so its elapsed time is zero
						wb.start_we = 1'b1;
						if (cfg.creep_dur == '0) begin
							wb.phase = ssdt_pkg::PH_CLEARED;
						end else begin
							wb.phase   = ssdt_pkg::PH_CREEP;
							res.kind   = ssdt_pkg::CK_CAP;
							res.target = tgt_cap;
							res.cap    = cfg.crawl_speed;
						end
					end
				end
				ssdt_pkg::PH_CREEP: begin
					if (creep_done) begin
						wb.phase = ssdt_pkg::PH_CLEARED;
					end else begin
						res.kind   = ssdt_pkg::CK_CAP;
						res.target = tgt_cap;
						res.cap    = cfg.crawl_speed;
					end
				end
				default: wb.phase = ssdt_pkg::PH_CLEARED;
			endcase
			res.phase = wb.phase;
		end
	end

endmodule

// ----- sim/tb_stop_sign_dwell_table_top.sv -----
// Testbench for the stop sign dwell table: directed script, phased random traffic, scoreboard.
`timescale 1ns / 1ps

module tb_stop_sign_dwell_table_top;

	localparam int DW             = ssdt_pkg::DIST_BITS_DEF;
	localparam int IDW            = ssdt_pkg::ID_W;
	localparam int SPW            = ssdt_pkg::SPEED_W;
	localparam int TW             = ssdt_pkg::TIME_W;
	localparam int TGW            = ssdt_pkg::TGT_W;
	localparam int CIW            = ssdt_pkg::CFG_IDX_W;
	localparam int CDW            = ssdt_pkg::CFG_DATA_W;
	localparam int CDSW           = ssdt_pkg::CFG_DIST_W;
	localparam int SLOTS          = ssdt_pkg::ID_SLOTS;
	localparam int WATCH          = 6;
	localparam int SEGMENTS       = 6;
	localparam int SEG_ITEMS      = 313;
	localparam int TAIL_CYCLES    = 20;
	localparam int WATCHDOG_LIMIT = 4000;

	// kind code the block must treat like "other"
	localparam logic [1:0] SK_UNUSED = 2'd3;

	typedef struct packed {
		ssdt_pkg::op_t       op;
		logic [IDW-1:0]      id;
		logic [1:0]          kind;
		logic [DW-1:0]       dist_mm;
		logic                paired;
		logic [DW-1:0]       paired_dist;
		logic [SPW-1:0]      speed;
		logic [TW-1:0]       now;
	} sign_item_t;

	typedef struct packed {
		sign_item_t     item;
		logic           typed;
		ssdt_pkg::res_t want;
	} script_row_t;

	localparam ssdt_pkg::res_t NO_WANT = '0;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	logic                  operation;
	logic [IDW-1:0]        sign_id;
	logic [1:0]            sign_kind;
	logic [DW-1:0]         sign_distance;
	logic                  paired_valid;
	logic [DW-1:0]         paired_distance;
	logic [SPW-1:0]        ego_speed;
	logic [TW-1:0]         now_ms;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [1:0]            constraint_kind;
	logic [TGW-1:0]        target_distance;
	logic [SPW-1:0]        speed_cap;
	logic                  from_yield;
	logic [1:0]            phase_after;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CIW-1:0]        cfg_index;
	logic [CDW-1:0]        cfg_data;

	stop_sign_dwell_table_top dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.operation       (operation),
		.sign_id         (sign_id),
		.sign_kind       (sign_kind),
		.sign_distance   (sign_distance),
		.paired_valid    (paired_valid),
		.paired_distance (paired_distance),
		.ego_speed       (ego_speed),
		.now_ms          (now_ms),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.constraint_kind (constraint_kind),
		.target_distance (target_distance),
		.speed_cap       (speed_cap),
		.from_yield      (from_yield),
		.phase_after     (phase_after),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// shadow of the block: settings and per-slot state
	ssdt_pkg::cfg_t     dwell_cfg = ssdt_pkg::CFG_RESET;
	ssdt_pkg::phase_t   slot_phase [SLOTS];
	logic [TW-1:0]      slot_since [SLOTS];
	bit                 slot_seen  [SLOTS];

	ssdt_pkg::res_t     pending_constraints [$];
	script_row_t        script_rows [$];
	logic [IDW-1:0]     watch_ids [WATCH];
	logic [TW-1:0]      frame_clock;

	int tx_idle_pct = 18;
	int rx_idle_pct = 54;
	int errors = 0;
	int items_sent = 0;
	int sweeps_sent = 0;
	int results_seen = 0;
	int phase_hits [4] = '{0, 0, 0, 0};
	int quiet_cycles = 0;

	initial begin
		foreach (slot_phase[s]) begin
			slot_phase[s] = ssdt_pkg::PH_APPROACH;
			slot_since[s] = '0;
			slot_seen[s]  = 1'b0;
		end
	end

	// constraint the block should produce for one item; updates the shadow table
	function automatic ssdt_pkg::res_t next_constraint(sign_item_t it);
		ssdt_pkg::res_t   r;
		ssdt_pkg::phase_t ph;
		logic [DW-1:0]    d;
		logic [DW-1:0]    adj;
		logic [TW-1:0]    elapsed;
		logic [TGW:0]     reach;
		r = NO_WANT;
		if (it.op == ssdt_pkg::OP_SWEEP) begin
			foreach (slot_phase[s]) begin
				if (!slot_seen[s] && slot_phase[s] != ssdt_pkg::PH_APPROACH)
					slot_phase[s] = ssdt_pkg::PH_CLEARED;
				slot_seen[s] = 1'b0;
			end
		end else if (it.kind == ssdt_pkg::SK_YIELD) begin
			r.kind       = ssdt_pkg::CK_CAP;
			r.target     = TGW'(it.dist_mm);
			r.cap        = dwell_cfg.yield_speed;
			r.from_yield = 1'b1;
		end else if (it.kind == ssdt_pkg::SK_STOP) begin
			d   = it.paired ? it.paired_dist : it.dist_mm;
			adj = (d > dwell_cfg.line_margin) ? d - dwell_cfg.line_margin : '0;
			ph  = slot_phase[it.id];
			slot_seen[it.id] = 1'b1;
			if (ph == ssdt_pkg::PH_APPROACH) begin
				if (it.speed < dwell_cfg.detect_speed && adj < dwell_cfg.line_tol) begin
					ph = ssdt_pkg::PH_HOLD;
					slot_since[it.id] = it.now;
				end
				r.kind   = ssdt_pkg::CK_STOP;
				r.target = TGW'(adj);
			end else begin
				if (ph == ssdt_pkg::PH_HOLD) begin
					elapsed = it.now - slot_since[it.id];
					if (elapsed < dwell_cfg.hold_time) begin
						r.kind   = ssdt_pkg::CK_STOP;
						r.target = TGW'(adj);
					end else begin
						// dwell done: creep starts now and is judged in the same item
						ph = ssdt_pkg::PH_CREEP;
						slot_since[it.id] = it.now;
					end
				end
				if (ph == ssdt_pkg::PH_CREEP) begin
					elapsed = it.now - slot_since[it.id];
					if (elapsed >= dwell_cfg.creep_dur) begin
						ph = ssdt_pkg::PH_CLEARED;
					end else begin
						reach    = {2'b00, adj} + {2'b00, dwell_cfg.crawl_reach};
						r.kind   = ssdt_pkg::CK_CAP;
						r.target = (reach > ssdt_pkg::TARGET_MAX) ?
							ssdt_pkg::TARGET_MAX : reach[TGW-1:0];
						r.cap    = dwell_cfg.crawl_speed;
					end
				end
			end
			slot_phase[it.id] = ph;
			r.phase = ph;
		end
		return r;
	endfunction

	function automatic void add_row(ssdt_pkg::op_t op, int id, logic [1:0] kind, int dist_mm,
			bit paired, int pdist, int speed, logic [TW-1:0] now, bit typed,
			ssdt_pkg::res_t want);
		script_row_t r;
		r.item.op          = op;
		r.item.id          = IDW'(id);
		r.item.kind        = kind;
		r.item.dist_mm     = DW'(dist_mm);
		r.item.paired      = paired;
		r.item.paired_dist = DW'(pdist);
		r.item.speed       = SPW'(speed);
		r.item.now         = now;
		r.typed            = typed;
		r.want             = want;
		script_rows = {script_rows, r};
	endfunction

	task automatic offer_item(sign_item_t it, bit typed, ssdt_pkg::res_t want);
		ssdt_pkg::res_t model;
		@(negedge clk);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		operation       = it.op;
		sign_id         = it.id;
		sign_kind       = it.kind;
		sign_distance   = it.dist_mm;
		paired_valid    = it.paired;
		paired_distance = it.paired_dist;
		ego_speed       = it.speed;
		now_ms          = it.now;
		in_valid        = 1'b1;
		do @(posedge clk); while (!in_ready);
		model = next_constraint(it);
		pending_constraints = {pending_constraints, (typed ? want : model)};
		items_sent++;
		if (it.op == ssdt_pkg::OP_SWEEP)
			sweeps_sent++;
	endtask

	task automatic wait_drained();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_constraints.size() != 0)
			@(posedge clk);
	endtask

	task automatic load_settings(ssdt_pkg::cfg_t c);
		ssdt_pkg::cfg_idx_t idx;
		logic [CDW-1:0]     val;
		for (int k = 0; k <= int'(ssdt_pkg::REG_STOP_MARGIN); k++) begin
			idx = ssdt_pkg::cfg_idx_t'(k);
			case (idx)
				ssdt_pkg::REG_DETECT_SPEED:  val = CDW'(c.detect_speed);
				ssdt_pkg::REG_LINE_TOL:      val = CDW'(c.line_tol);
				ssdt_pkg::REG_HOLD_TIME:     val = CDW'(c.hold_time);
				ssdt_pkg::REG_CREEP_DUR:     val = CDW'(c.creep_dur);
				ssdt_pkg::REG_CREEP_SPEED:   val = CDW'(c.crawl_speed);
				ssdt_pkg::REG_CREEP_ADVANCE: val = CDW'(c.crawl_reach);
				ssdt_pkg::REG_YIELD_SPEED:   val = CDW'(c.yield_speed);
				default:                     val = CDW'(c.line_margin);
			endcase
			@(negedge clk);
			cfg_index = idx;
			cfg_data  = val;
			cfg_valid = 1'b1;
			do @(posedge clk); while (!cfg_ready);
		end
		@(negedge clk);
		cfg_valid = 1'b0;
		dwell_cfg = c;
	endtask

	// mostly stop signs on a few tracked slots with advancing time, so slots
	// walk through hold and creep; the rest is give-way/other, sweeps and noise
	task automatic run_traffic(int count);
		sign_item_t     it;
		int             pick;
		int             span;
		int             near_line;
		logic [DW-1:0]  d;
		span = ((dwell_cfg.hold_time > dwell_cfg.creep_dur) ? int'(dwell_cfg.hold_time)
			: int'(dwell_cfg.creep_dur)) / 3 + 20;
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(0, 99) < 3)
				watch_ids[$urandom_range(0, WATCH - 1)] = IDW'($urandom);
			it.op          = ssdt_pkg::OP_SIGN;
			it.id          = IDW'($urandom);
			it.kind        = 2'($urandom_range(0, 3));
			it.dist_mm     = DW'($urandom);
			it.paired      = 1'($urandom);
			it.paired_dist = DW'($urandom);
			it.speed       = SPW'($urandom);
			it.now         = $urandom;
			pick = $urandom_range(0, 99);
			if (pick < 5) begin
				it.op = ssdt_pkg::OP_SWEEP;
			end else if (pick >= 15 && pick < 25) begin
				it.id  = watch_ids[$urandom_range(0, WATCH - 1)];
				it.now = frame_clock;
				case ($urandom_range(0, 2))
					0:       it.kind = ssdt_pkg::SK_OTHER;
					1:       it.kind = ssdt_pkg::SK_YIELD;
					default: it.kind = SK_UNUSED;
				endcase
			end else if (pick >= 25) begin
				frame_clock += TW'($urandom_range(0, span));
				it.id   = watch_ids[$urandom_range(0, WATCH - 1)];
				it.kind = ssdt_pkg::SK_STOP;
				it.now  = frame_clock;
				if (dwell_cfg.detect_speed != 0 && $urandom_range(0, 9) < 7)
					it.speed = SPW'($urandom_range(0, dwell_cfg.detect_speed - 1));
				if ($urandom_range(0, 9) < 7) begin
					near_line = int'(dwell_cfg.line_margin) + $urandom_range(0,
						(dwell_cfg.line_tol != 0) ? dwell_cfg.line_tol - 1 : 0);
					d = (near_line > 32'hFFFFF) ? '1 : DW'(near_line);
				end else begin
					d = DW'($urandom);
				end
				if (it.paired)
					it.paired_dist = d;
				else
					it.dist_mm = d;
			end
			offer_item(it, 1'b0, NO_WANT);
		end
	endtask

	task automatic note_mismatch(string field, longint want, longint got);
		errors++;
		$display("%0t: %s expected %0d got %0d", $time, field, want, got);
	endtask

	always @(negedge clk)
		out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);

	// scoreboard
	always @(posedge clk) begin
		ssdt_pkg::res_t want;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			phase_hits[phase_after]++;
			if (pending_constraints.size() == 0) begin
				errors++;
				$display("%0t: result with no item outstanding, kind %0d target %0d",
					$time, constraint_kind, target_distance);
			end else begin
				want = pending_constraints.pop_front();
				if (constraint_kind != want.kind)
					note_mismatch("constraint_kind", want.kind, constraint_kind);
				if (target_distance != want.target)
					note_mismatch("target_distance", want.target, target_distance);
				if (speed_cap != want.cap)
					note_mismatch("speed_cap", want.cap, speed_cap);
				if (from_yield != want.from_yield)
					note_mismatch("from_yield", want.from_yield, from_yield);
				if (phase_after != want.phase)
					note_mismatch("phase_after", want.phase, phase_after);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
			$display("simulation failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		ssdt_pkg::cfg_t setting;
		arst_n          = 1'b0;
		in_valid        = 1'b0;
		operation       = ssdt_pkg::OP_SIGN;
		sign_id         = '0;
		sign_kind       = ssdt_pkg::SK_OTHER;
		sign_distance   = '0;
		paired_valid    = 1'b0;
		paired_distance = '0;
		ego_speed       = '0;
		now_ms          = '0;
		cfg_valid       = 1'b0;
		cfg_index       = ssdt_pkg::REG_DETECT_SPEED;
		cfg_data        = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset settings throughout the script
		add_row(ssdt_pkg::OP_SWEEP, 0, ssdt_pkg::SK_OTHER, 0, 0, 0, 0, 0, 1, NO_WANT);
		add_row(ssdt_pkg::OP_SIGN, 0, ssdt_pkg::SK_YIELD, 0, 0, 0, 0, 0, 1,
			'{ssdt_pkg::CK_CAP, 21'd0, 16'd2000, 1'b1, ssdt_pkg::PH_APPROACH});
		add_row(ssdt_pkg::OP_SIGN, 255, ssdt_pkg::SK_YIELD, 'hFFFFF, 1, 'hFFFFF, 'hFFFF,
			32'hFFFF_FFFF, 1,
			'{ssdt_pkg::CK_CAP, 21'd1048575, 16'd2000, 1'b1, ssdt_pkg::PH_APPROACH});
		add_row(ssdt_pkg::OP_SIGN, 7, ssdt_pkg::SK_OTHER, 1234, 0, 0, 0, 0, 1, NO_WANT);
		add_row(ssdt_pkg::OP_SIGN, 8, SK_UNUSED, 1234, 1, 77, 0, 0, 1, NO_WANT);
		add_row(ssdt_pkg::OP_SIGN, 255, ssdt_pkg::SK_STOP, 'hFFFFF, 0, 0, 'hFFFF, 0, 1,
			'{ssdt_pkg::CK_STOP, 21'd1048075, 16'd0, 1'b0, ssdt_pkg::PH_APPROACH});
		// slot 1: hold, paired line, creep, sweep while seen, cleared
		add_row(ssdt_pkg::OP_SIGN, 1, ssdt_pkg::SK_STOP, 100, 0, 0, 0, 5000, 1,
			'{ssdt_pkg::CK_STOP, 21'd0, 16'd0, 1'b0, ssdt_pkg::PH_HOLD});
		add_row(ssdt_pkg::OP_SIGN, 1, ssdt_pkg::SK_STOP, 'hFFFFF, 1, 1400, 0, 6000, 1,
			'{ssdt_pkg::CK_STOP, 21'd900, 16'd0, 1'b0, ssdt_pkg::PH_HOLD});
		add_row(ssdt_pkg::OP_SIGN, 1, ssdt_pkg::SK_STOP, 600, 0, 0, 0, 7000, 0, NO_WANT);
		add_row(ssdt_pkg::OP_SIGN, 1, ssdt_pkg::SK_STOP, 600, 0, 0, 0, 7999, 0, NO_WANT);
		add_row(ssdt_pkg::OP_SWEEP, 0, ssdt_pkg::SK_OTHER, 0, 0, 0, 0, 0, 0, NO_WANT);
		add_row(ssdt_pkg::OP_SIGN, 1, ssdt_pkg::SK_STOP, 600, 0, 0, 0, 8000, 1,
			'{ssdt_pkg::CK_NONE, 21'd0, 16'd0, 1'b0, ssdt_pkg::PH_CLEARED});
		// slot 2: hold across the time wrap, then cleared by an unseen sweep
		add_row(ssdt_pkg::OP_SIGN, 2, ssdt_pkg::SK_STOP, 1499, 0, 0, 299, 32'hFFFF_FF00, 1,
			'{ssdt_pkg::CK_STOP, 21'd999, 16'd0, 1'b0, ssdt_pkg::PH_HOLD});
		add_row(ssdt_pkg::OP_SIGN, 2, ssdt_pkg::SK_STOP, 1499, 0, 0, 5000, 32'h0000_0100, 0,
			NO_WANT);
		// slot 3: both stop conditions right at their limits
		add_row(ssdt_pkg::OP_SIGN, 3, ssdt_pkg::SK_STOP, 1500, 0, 0, 0, 100, 0, NO_WANT);
		add_row(ssdt_pkg::OP_SIGN, 3, ssdt_pkg::SK_STOP, 0, 0, 0, 300, 200, 0, NO_WANT);
		add_row(ssdt_pkg::OP_SWEEP, 0, ssdt_pkg::SK_OTHER, 0, 0, 0, 0, 0, 0, NO_WANT);
		add_row(ssdt_pkg::OP_SWEEP, 0, ssdt_pkg::SK_OTHER, 0, 0, 0, 0, 0, 0, NO_WANT);
		add_row(ssdt_pkg::OP_SIGN, 2, ssdt_pkg::SK_STOP, 1499, 0, 0, 0, 32'h0000_0300, 0,
			NO_WANT);
		// slot 4: hold time met exactly, creep, cleared by sweep
		add_row(ssdt_pkg::OP_SIGN, 4, ssdt_pkg::SK_STOP, 500, 0, 0, 0, 1000, 0, NO_WANT);
		add_row(ssdt_pkg::OP_SIGN, 4, ssdt_pkg::SK_STOP, 500, 0, 0, 0, 3000, 0, NO_WANT);
		add_row(ssdt_pkg::OP_SWEEP, 0, ssdt_pkg::SK_OTHER, 0, 0, 0, 0, 0, 0, NO_WANT);
		add_row(ssdt_pkg::OP_SWEEP, 0, ssdt_pkg::SK_OTHER, 0, 0, 0, 0, 0, 0, NO_WANT);
		add_row(ssdt_pkg::OP_SIGN, 4, ssdt_pkg::SK_STOP, 500, 0, 0, 0, 3100, 0, NO_WANT);

		foreach (script_rows[i])
			offer_item(script_rows[i].item, script_rows[i].typed, script_rows[i].want);
		wait_drained();

		frame_clock = 32'hFFFF_FFFF - TW'($urandom_range(0, 500000));
		foreach (watch_ids[w])
			watch_ids[w] = IDW'($urandom);
		for (int seg = 0; seg < SEGMENTS; seg++) begin
			case (seg / 2)
				0: begin tx_idle_pct = 18; rx_idle_pct = 54; end
				1: begin tx_idle_pct = 54; rx_idle_pct = 18; end
				default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
			endcase
			case (seg)
				0: setting = ssdt_pkg::CFG_RESET;
				1: setting = '0;
				2: setting = '1;
				default: begin
					setting.detect_speed = SPW'($urandom);
					setting.line_tol     = CDSW'($urandom);
					setting.crawl_speed  = SPW'($urandom);
					setting.crawl_reach  = CDSW'($urandom);
					setting.yield_speed  = SPW'($urandom);
					setting.line_margin  = CDSW'($urandom);
					if (seg == 3) begin
						setting.hold_time = SPW'($urandom_range(0, 3000));
						setting.creep_dur = SPW'($urandom_range(0, 3000));
					end else if (seg == 4) begin
						setting.hold_time = SPW'($urandom_range(0, 50));
						setting.creep_dur = SPW'($urandom_range(0, 50));
					end else begin
						setting.hold_time = SPW'($urandom);
						setting.creep_dur = SPW'($urandom);
					end
				end
			endcase
			load_settings(setting);
			run_traffic(SEG_ITEMS);
			wait_drained();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (pending_constraints.size() != 0) begin
			errors++;
			$display("%0t: %0d results never arrived", $time, pending_constraints.size());
		end

		$display("Ran %0d items (%0d frame sweeps) over %0d register settings, %0d results",
			items_sent, sweeps_sent, SEGMENTS + 1, results_seen);
		$display("Slot phases reported: hold %0d, creep %0d, cleared %0d; mismatches %0d",
			phase_hits[ssdt_pkg::PH_HOLD], phase_hits[ssdt_pkg::PH_CREEP],
			phase_hits[ssdt_pkg::PH_CLEARED], errors);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
